// ===== hw/rtl/u8d_pkg.sv =====
`default_nettype none

package u8d_pkg;

    localparam int ByteW = 8;
    localparam int CodeW = 31;
    localparam int CntW  = 3;
    localparam int StatW = 2;
    localparam int ContW = 6;
    localparam int LeadW = 5;

    // Lead byte masks and match values
    localparam logic [ByteW-1:0] MaskAscii = 8'b1000_0000;
    localparam logic [ByteW-1:0] Mask2     = 8'b1110_0000;
    localparam logic [ByteW-1:0] Lead2     = 8'b1100_0000;
    localparam logic [ByteW-1:0] Mask3     = 8'b1111_0000;
    localparam logic [ByteW-1:0] Lead3     = 8'b1110_0000;
    localparam logic [ByteW-1:0] Mask4     = 8'b1111_1000;
    localparam logic [ByteW-1:0] Lead4     = 8'b1111_0000;
    localparam logic [ByteW-1:0] Mask5     = 8'b1111_1100;
    localparam logic [ByteW-1:0] Lead5     = 8'b1111_1000;
    localparam logic [ByteW-1:0] Mask6     = 8'b1111_1110;
    localparam logic [ByteW-1:0] Lead6     = 8'b1111_1100;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    // Classification of one byte taken as a lead byte
    typedef struct packed {
        logic             is_ascii;
        logic             is_invalid;
        logic [CntW-1:0]  extra;     // continuation bytes that follow
        logic [LeadW-1:0] payload;
    } t_lead;

    // One step's outcome
    typedef struct packed {
        logic             emit;
        logic [CodeW-1:0] code;
        t_status          status;
    } t_res;

endpackage

`default_nettype wire

// ===== hw/rtl/u8d_if.sv =====
`default_nettype none

interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface u8d_code_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic [1:0]  status;

    modport source (output valid, output code_point, output status, input ready);
    modport sink   (input valid, input code_point, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8d_lead_dec.sv =====
`default_nettype none

module u8d_lead_dec (
    input  wire logic [u8d_pkg::ByteW-1:0] i_byte,
    output u8d_pkg::t_lead                 o_lead
);
    import u8d_pkg::*;

    always_comb begin
        o_lead = '0;
        if ((i_byte & MaskAscii) == '0) begin
            o_lead.is_ascii = 1'b1;
        end else if ((i_byte & Mask2) == Lead2) begin
            o_lead.extra   = CntW'(1);
            o_lead.payload = i_byte[4:0];
        end else if ((i_byte & Mask3) == Lead3) begin
            o_lead.extra   = CntW'(2);
            o_lead.payload = {1'b0, i_byte[3:0]};
        end else if ((i_byte & Mask4) == Lead4) begin
            o_lead.extra   = CntW'(3);
            o_lead.payload = {2'b0, i_byte[2:0]};
        end else if ((i_byte & Mask5) == Lead5) begin
            o_lead.extra   = CntW'(4);
            o_lead.payload = {3'b0, i_byte[1:0]};
        end else if ((i_byte & Mask6) == Lead6) begin
            o_lead.extra   = CntW'(5);
            o_lead.payload = {4'b0, i_byte[0]};
        end else begin
            // stray continuation byte, FE or FF
            o_lead.is_invalid = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u8d_step.sv =====
`default_nettype none

module u8d_step (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_fire,
    input  wire logic [u8d_pkg::ByteW-1:0] i_byte,
    input  wire logic                      i_last,
    output u8d_pkg::t_res                  o_res
);
    import u8d_pkg::*;

    logic [CodeW-1:0] r_partial, n_partial;
    logic [CntW-1:0]  r_remain,  n_remain;
    logic [CodeW-1:0] shifted;
    logic [CntW-1:0]  remain_dec;
    t_lead            lead;

    u8d_lead_dec u_lead (
        .i_byte (i_byte),
        .o_lead (lead)
    );

    assign shifted    = {r_partial[CodeW-ContW-1:0], i_byte[ContW-1:0]};
    assign remain_dec = r_remain - CntW'(1);

    always_comb begin
        o_res     = '0;
        n_partial = r_partial;
        n_remain  = r_remain;
        if (r_remain != '0) begin
            if (remain_dec == '0) begin
                o_res.emit   = 1'b1;
                o_res.code   = shifted;
                o_res.status = ST_OK;
                n_partial    = '0;
                n_remain     = '0;
            end else if (i_last) begin
                o_res.emit   = 1'b1;
                o_res.status = ST_TRUNCATED;
                n_partial    = '0;
                n_remain     = '0;
            end else begin
                n_partial = shifted;
                n_remain  = remain_dec;
            end
        end else if (lead.is_ascii) begin
            o_res.emit   = 1'b1;
            o_res.code   = CodeW'(i_byte);
            o_res.status = ST_OK;
        end else if (lead.is_invalid) begin
            o_res.emit   = 1'b1;
            o_res.status = ST_INVALID;
        end else if (i_last) begin
            // lead of a multi-byte sequence on the buffer's last byte
            o_res.emit   = 1'b1;
            o_res.status = ST_TRUNCATED;
        end else begin
            n_partial = CodeW'(lead.payload);
            n_remain  = lead.extra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_remain  <= '0;
        end else if (i_fire) begin
            r_partial <= n_partial;
            r_remain  <= n_remain;
        end
    end

`ifndef ASSERT_OFF
    a_remain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remain <= CntW'(5))
        else $error("continuation count out of range");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.emit && o_res.status != ST_OK) |-> (o_res.code == '0))
        else $error("error result with nonzero code point");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.emit) |=> (r_remain == '0 && r_partial == '0))
        else $error("state not cleared after a result");

    a_hold_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !o_res.emit) |=> (r_remain != '0))
        else $error("byte without result left no open sequence");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_extended_decoder.sv =====
`default_nettype none

// Channel  Dir  Modport          Payload
// i_byte   in   u8d_byte_if.sink    data_byte[7:0], end_of_buffer
// o_code   out  u8d_code_if.source  code_point[30:0], status[1:0]
//
// One byte per cycle unless a held result stalls the input; each result passes
// through the input register, then the result register.
// The only loop is the sequence state update.
// Synchronous active-low reset empties both registers and waits for a lead.
// A held result stalls the input register only for a byte that also yields
// a result; bytes that open or extend a sequence keep flowing.

module utf8_extended_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8d_byte_if.sink    i_byte,
    u8d_code_if.source  o_code
);
    import u8d_pkg::*;

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    logic [CodeW-1:0] r_out_code;
    t_status          r_out_status;
    t_res             res;
    logic             out_free;
    logic             s1_fire;

    assign out_free     = !r_out_valid || o_code.ready;
    assign s1_fire      = r_in_valid && (!res.emit || out_free);
    assign i_byte.ready = !r_in_valid || s1_fire;

    u8d_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.end_of_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load payload only on a new result; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (s1_fire && res.emit) begin
            r_out_code   <= res.code;
            r_out_status <= res.status;
        end
    end

    assign o_code.valid      = r_out_valid;
    assign o_code.code_point = r_out_code;
    assign o_code.status     = r_out_status;

endmodule

`default_nettype wire

// ===== sim/tb_utf8_extended_decoder.sv =====
`default_nettype none

module tb_utf8_extended_decoder;
    import u8d_pkg::*;

    localparam int TotalItems  = 1850;
    localparam int HoldAfter   = 700;
    localparam int PauseAfter  = 1000;
    localparam int LongHold    = 400;
    localparam int DrainCycles = 16;
    localparam int CycleLimit  = 400000;

    // {data_byte, end_of_buffer}
    localparam logic [8:0] DirectedBytes [24] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0},
        {8'hC0, 1'b0}, {8'h80, 1'b0},
        {8'hEF, 1'b0}, {8'hFF, 1'b0}, {8'h3F, 1'b0},
        {8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'hFD, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'h80, 1'b0}, {8'hFE, 1'b0}, {8'hFF, 1'b1},
        {8'hF0, 1'b1},
        {8'hE0, 1'b0}, {8'h80, 1'b1},
        {8'h7F, 1'b1}
    };

    typedef struct {
        logic [CodeW-1:0] code;
        t_status          status;
    } t_char_result;

    class utf8_char_scoreboard;
        logic [CodeW-1:0] partial;
        logic [CntW-1:0]  remaining;
        t_char_result     expected_chars[$];

        function new();
            partial   = '0;
            remaining = '0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void push_char(logic [CodeW-1:0] code, t_status status);
            t_char_result c;
            c.code   = code;
            c.status = status;
            expected_chars = {expected_chars, c};
        endfunction

        function void note_byte(logic [ByteW-1:0] b, logic eob);
            logic [CodeW-1:0] payload;
            logic [CntW-1:0]  extra;
            payload = '0;
            extra   = '0;
            if (remaining != 0) begin
                partial   = {partial[CodeW-ContW-1:0], b[ContW-1:0]};
                remaining = remaining - 1'b1;
                if (remaining == 0) begin
                    push_char(partial, ST_OK);
                    partial = '0;
                end else if (eob) begin
                    push_char('0, ST_TRUNCATED);
                    partial   = '0;
                    remaining = '0;
                end
                return;
            end
            if ((b & MaskAscii) == '0) begin
                push_char(CodeW'(b), ST_OK);
                return;
            end else if ((b & Mask2) == Lead2) begin
                extra   = 3'd1;
                payload = CodeW'(b & ~Mask2);
            end else if ((b & Mask3) == Lead3) begin
                extra   = 3'd2;
                payload = CodeW'(b & ~Mask3);
            end else if ((b & Mask4) == Lead4) begin
                extra   = 3'd3;
                payload = CodeW'(b & ~Mask4);
            end else if ((b & Mask5) == Lead5) begin
                extra   = 3'd4;
                payload = CodeW'(b & ~Mask5);
            end else if ((b & Mask6) == Lead6) begin
                extra   = 3'd5;
                payload = CodeW'(b & ~Mask6);
            end else begin
                push_char('0, ST_INVALID);
                return;
            end
            // a multi-byte lead that closes the buffer is cut off at once
            if (eob) begin
                push_char('0, ST_TRUNCATED);
            end else begin
                partial   = payload;
                remaining = extra;
            end
        endfunction

        function string check_char(logic [CodeW-1:0] code, logic [StatW-1:0] status);
            t_char_result want;
            string        why;
            why = "";
            if (expected_chars.size() == 0)
                return $sformatf("unexpected result code_point=%h status=%0d", code, status);
            want = expected_chars.pop_front();
            if (code !== want.code)
                why = $sformatf("code_point %h, want %h", code, want.code);
            if (status !== want.status)
                why = {why, $sformatf(" status %0d, want %0d", status, want.status)};
            return why;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    u8d_byte_if byte_if ();
    u8d_code_if code_if ();

    utf8_extended_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_code  (code_if)
    );

    utf8_char_scoreboard sb = new();

    int mismatches    = 0;
    int bytes_sent    = 0;
    int buffers_sent  = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int n_ok          = 0;
    int n_invalid     = 0;
    int n_truncated   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string why);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, why);
    endtask

    // Offer one byte and hold it until the transaction completes.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        byte_if.valid         <= 1'b1;
        byte_if.data_byte     <= b;
        byte_if.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        sb.note_byte(b, eob);
        bytes_sent++;
    endtask

    function automatic logic [7:0] lead_byte(int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       return r & ~MaskAscii;
            2:       return Lead2 | (r & ~Mask2);
            3:       return Lead3 | (r & ~Mask3);
            4:       return Lead4 | (r & ~Mask4);
            5:       return Lead5 | (r & ~Mask5);
            default: return Lead6 | (r & ~Mask6);
        endcase
    endfunction

    // Mostly proper continuation bytes; the rest any value at all.
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Build one buffer of a few units and send it, end_of_buffer on its last byte.
    task automatic send_random_buffer(input bit ascii_heavy);
        logic [7:0] buf_bytes[$];
        int         n_units;
        int         kind;
        int         len;
        int         cut;
        bit         closed;
        buf_bytes = {};
        closed    = 1'b0;
        n_units   = $urandom_range(1, 8);
        for (int u = 0; u < n_units && !closed; u++) begin
            kind = $urandom_range(0, 99);
            if (ascii_heavy && kind < 50) begin
                buf_bytes = {buf_bytes, lead_byte(1)};
            end else if (kind < 70) begin
                len = $urandom_range(1, 6);
                buf_bytes = {buf_bytes, lead_byte(len)};
                for (int k = 1; k < len; k++) buf_bytes = {buf_bytes, cont_byte()};
            end else if (kind < 80) begin
                case ($urandom_range(0, 2))
                    0:       buf_bytes = {buf_bytes, 8'hFE};
                    1:       buf_bytes = {buf_bytes, 8'hFF};
                    default: buf_bytes = {buf_bytes, 8'h80 | 8'($urandom_range(0, 63))};
                endcase
            end else if (kind < 90) begin
                // cut a sequence short: the buffer ends inside it
                len = $urandom_range(2, 6);
                cut = $urandom_range(0, len - 2);
                buf_bytes = {buf_bytes, lead_byte(len)};
                for (int k = 0; k < cut; k++) buf_bytes = {buf_bytes, cont_byte()};
                closed = 1'b1;
            end else begin
                buf_bytes = {buf_bytes, 8'($urandom)};
            end
        end
        foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        buffers_sent++;
    endtask

    // Result side: check, then pick the next ready.
    initial begin
        int    rx_mode;
        int    mode_left;
        int    hold_left;
        int    hold_seen;
        string why;
        rx_mode   = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        code_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && code_if.valid && code_if.ready) begin
                why = sb.check_char(code_if.code_point, code_if.status);
                if (why != "") report_mismatch(why);
                if (code_if.status == ST_OK) n_ok++;
                else if (code_if.status == ST_INVALID) n_invalid++;
                else n_truncated++;
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LongHold;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                code_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       code_if.ready <= 1'b1;
                    1:       code_if.ready <= ($urandom_range(0, 9) < 7);
                    2:       code_if.ready <= (mode_left % 5 != 0);
                    default: code_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n               <= 1'b0;
        byte_if.valid         <= 1'b0;
        byte_if.data_byte     <= '0;
        byte_if.end_of_buffer <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DirectedBytes[i]) send_byte(DirectedBytes[i][8:1], DirectedBytes[i][0]);

        while (bytes_sent < HoldAfter) send_random_buffer(1'b0);

        // stall the result side for a long stretch while bytes keep coming
        hold_requests++;
        while (bytes_sent < PauseAfter) send_random_buffer(1'b1);

        // pause until every pending character has come out
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        burst_left = 0;

        while (bytes_sent < TotalItems) send_random_buffer(1'b0);
        byte_if.valid <= 1'b0;

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("sent %0d bytes in %0d buffers, all lead lengths, invalid leads, truncations",
                 bytes_sent, buffers_sent);
        $display("checked %0d characters, %0d invalid, %0d truncated; %0d mismatches",
                 n_ok, n_invalid, n_truncated, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_if.sv
hw/rtl/u8d_lead_dec.sv
hw/rtl/u8d_step.sv
hw/rtl/utf8_extended_decoder.sv
sim/tb_utf8_extended_decoder.sv
